/* rtl/tts_pkg.sv */
// Shared constants, codes and control structs for the target smoothing table.
package tts_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int KEY_W    = 16;
  localparam int WGT_W    = 16;
  localparam int COMP_W   = 32;
  localparam int STAMP_W  = 64;
  localparam int N_COMP   = 6;
  localparam int COMP_CW  = 3;
  localparam int STAMP_LO = N_COMP * COMP_W;
  localparam int ROW_W    = STAMP_LO + STAMP_W;

  localparam logic [WGT_W-1:0] KEEP_WEIGHT_RST = 16'd52429;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_CREATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic               load;     // capture transaction, clear search flags
    logic               scan_rd;  // read key memory at idx
    logic [IDX_W-1:0]   idx;
    logic               row_rd;   // read data row of the hit entry
    logic               res_row;  // result <= fetched row
    logic               res_zero; // result <= zeros
    logic               create;   // write raw row into the free entry
    logic               mul_en;   // product for component comp
    logic               acc_en;   // add back product of previous component
    logic [COMP_CW-1:0] comp;
    logic               wr_upd;   // write smoothed row back to the hit entry
    status_t            code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic free;
    logic func;
  } sts_t;

endpackage

/* rtl/tts_dp.sv */
// Datapath: key and row memories, valid bits, key search and smoothing multiplier.
module tts_dp
  import tts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [WGT_W-1:0]        cfg_keep_weight,
  input  logic                    in_func,
  input  logic [KEY_W-1:0]        in_target_id,
  input  logic [ROW_W-1:0]        in_row,
  output logic [2:0]              res_status,
  output logic [ROW_W-1:0]        res_row
);

  logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
  logic [ROW_W-1:0]         dat_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [WGT_W-1:0]   wgt_r;
  logic               func_r;
  logic [KEY_W-1:0]   key_r;
  logic [ROW_W-1:0]   in_row_r;

  logic [KEY_W-1:0]   key_q_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;

  logic [ROW_W-1:0]   row_q_r;
  logic [ROW_W-1:0]   res_r;
  status_t            status_r;

  logic signed [2*COMP_W-15:0] prod_r;   // 33 x 17 signed
  logic [COMP_CW-1:0]          prod_c_r;

  logic [COMP_W-1:0]           old_c;
  logic [COMP_W-1:0]           in_c;
  logic [COMP_W-1:0]           in_acc;
  logic signed [COMP_W:0]      diff;
  logic signed [WGT_W:0]       wgt_s;
  logic [COMP_W-1:0]           smooth_c;

  always_comb begin
    old_c    = row_q_r[cmd.comp * COMP_W +: COMP_W];
    in_c     = in_row_r[cmd.comp * COMP_W +: COMP_W];
    diff     = signed'({old_c[COMP_W-1], old_c}) - signed'({in_c[COMP_W-1], in_c});
    wgt_s    = signed'({1'b0, wgt_r});
    in_acc   = in_row_r[prod_c_r * COMP_W +: COMP_W];
    // floor(p / 2^16) is an arithmetic shift; only its low 32 bits are kept
    smooth_c = in_acc + prod_r[WGT_W +: COMP_W];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_r     <= KEEP_WEIGHT_RST;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        wgt_r <= cfg_keep_weight;
      end
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.create) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (valid_r[cmp_idx_r]) begin
          if (!hit_r && key_q_r == key_r) begin
            hit_r <= 1'b1;
          end
        end else if (!free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      key_r    <= in_target_id;
      in_row_r <= in_row;
    end
    if (cmd.scan_rd) begin
      key_q_r   <= key_mem[cmd.idx];
      cmp_idx_r <= cmd.idx;
    end
    if (cmp_vld_r && !cmd.load) begin
      if (valid_r[cmp_idx_r]) begin
        if (!hit_r && key_q_r == key_r) begin
          hit_idx_r <= cmp_idx_r;
        end
      end else if (!free_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.row_rd) begin
      row_q_r <= dat_mem[hit_idx_r];
    end
    if (cmd.create) begin
      key_mem[free_idx_r] <= key_r;
      dat_mem[free_idx_r] <= in_row_r;
    end else if (cmd.wr_upd) begin
      dat_mem[hit_idx_r] <= {in_row_r[STAMP_LO +: STAMP_W], res_r[STAMP_LO-1:0]};
    end
    if (cmd.mul_en) begin
      prod_r   <= diff * wgt_s;
      prod_c_r <= cmd.comp;
    end
    if (cmd.res_zero) begin
      res_r <= '0;
    end else if (cmd.res_row) begin
      res_r <= row_q_r;
    end else if (cmd.create) begin
      res_r <= in_row_r;
    end else if (cmd.wr_upd) begin
      res_r[STAMP_LO +: STAMP_W] <= in_row_r[STAMP_LO +: STAMP_W];
    end else if (cmd.acc_en) begin
      res_r[prod_c_r * COMP_W +: COMP_W] <= smooth_c;
    end
    if (cmd.res_zero || cmd.res_row || cmd.create || cmd.wr_upd) begin
      status_r <= cmd.code;
    end
  end

  assign sts.hit    = hit_r;
  assign sts.free   = free_r;
  assign sts.func   = func_r;
  assign res_status = status_r;
  assign res_row    = res_r;

endmodule

/* rtl/tts_ctrl.sv */
// Controller: sequences key scan, row fetch, smoothing and write-back.
module tts_ctrl
  import tts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_FETCH,
    S_CALC,
    S_WRITE
  } state_t;

  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [COMP_CW-1:0] LAST_COMP = COMP_CW'(N_COMP);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [COMP_CW-1:0] comp_r, comp_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    comp_nxt      = comp_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.idx       = cnt_r;
    cmd.comp      = comp_r;
    cmd.code      = ST_UPDATED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_DECIDE;  // last key compare lands this cycle
      end
      S_DECIDE: begin
        if (sts.hit) begin
          cmd.row_rd = 1'b1;
          state_nxt  = S_FETCH;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (sts.func == FUNC_READ) begin
            cmd.res_zero = 1'b1;
            cmd.code     = ST_NOT_FOUND;
          end else if (sts.free) begin
            cmd.create = 1'b1;
            cmd.code   = ST_CREATED;
          end else begin
            cmd.res_zero = 1'b1;
            cmd.code     = ST_FULL;
          end
        end
      end
      S_FETCH: begin
        if (sts.func == FUNC_READ) begin
          cmd.res_row   = 1'b1;
          cmd.code      = ST_FOUND;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.res_row = 1'b1;
          comp_nxt    = '0;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        // multiply component comp while adding back comp-1
        cmd.mul_en = (comp_r != LAST_COMP);
        cmd.acc_en = (comp_r != '0);
        comp_nxt   = comp_r + 1'b1;
        if (comp_r == LAST_COMP) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_upd    = 1'b1;
        cmd.code      = ST_UPDATED;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/tracked_target_smoothing_table.sv */
// Top level of the keyed target smoothing table.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | start / busy       | in_func, in_target_id, in_pos_*, in_vel_*,
//            |                    | in_stamp
//   result   | out_valid (strobe) | out_status, out_pos_*, out_vel_*, out_stamp
//   config   | cfg_we             | cfg_keep_weight
//
// A transaction scans all TABLE_ENTRIES keys, one key memory read per cycle.
// The result strobe follows the scan and S_DECIDE for a miss, then S_FETCH for a read
// hit; S_FETCH, S_CALC and S_WRITE for an update hit (six products on one multiplier).
// busy drops in the cycle the result is shown; a new transaction may start then.
// Synchronous active-low reset clears the valid bits and restores keep_weight.
// The receiver cannot stall; each result is shown for one cycle only.
module tracked_target_smoothing_table
  import tts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [KEY_W-1:0]    in_target_id,
  input  logic [COMP_W-1:0]   in_pos_x,
  input  logic [COMP_W-1:0]   in_pos_y,
  input  logic [COMP_W-1:0]   in_pos_z,
  input  logic [COMP_W-1:0]   in_vel_x,
  input  logic [COMP_W-1:0]   in_vel_y,
  input  logic [COMP_W-1:0]   in_vel_z,
  input  logic [STAMP_W-1:0]  in_stamp,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [COMP_W-1:0]   out_pos_x,
  output logic [COMP_W-1:0]   out_pos_y,
  output logic [COMP_W-1:0]   out_pos_z,
  output logic [COMP_W-1:0]   out_vel_x,
  output logic [COMP_W-1:0]   out_vel_y,
  output logic [COMP_W-1:0]   out_vel_z,
  output logic [STAMP_W-1:0]  out_stamp,
  input  logic                cfg_we,
  input  logic [WGT_W-1:0]    cfg_keep_weight
);

  cmd_t             cmd;
  sts_t             sts;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] res_row;

  assign in_row = {in_stamp, in_vel_z, in_vel_y, in_vel_x, in_pos_z, in_pos_y, in_pos_x};

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_keep_weight (cfg_keep_weight),
    .in_func         (in_func),
    .in_target_id    (in_target_id),
    .in_row          (in_row),
    .res_status      (out_status),
    .res_row         (res_row)
  );

  assign out_pos_x = res_row[0*COMP_W +: COMP_W];
  assign out_pos_y = res_row[1*COMP_W +: COMP_W];
  assign out_pos_z = res_row[2*COMP_W +: COMP_W];
  assign out_vel_x = res_row[3*COMP_W +: COMP_W];
  assign out_vel_y = res_row[4*COMP_W +: COMP_W];
  assign out_vel_z = res_row[5*COMP_W +: COMP_W];
  assign out_stamp = res_row[STAMP_LO +: STAMP_W];

endmodule

/* sim/tb_top.sv */
// Testbench for the keyed target smoothing table: directed and random traffic, scoreboarded.
module tb_top
  import tts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic                           func;
    logic [KEY_W-1:0]               id;
    logic [2:0][COMP_W-1:0]         pos;
    logic [2:0][COMP_W-1:0]         vel;
    logic [STAMP_W-1:0]             stamp;
  } track_cmd_t;

  typedef struct packed {
    status_t                        status;
    logic [2:0][COMP_W-1:0]         pos;
    logic [2:0][COMP_W-1:0]         vel;
    logic [STAMP_W-1:0]             stamp;
  } track_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [WGT_W-1:0] cfg_keep_weight = '0;
  track_cmd_t in_cmd = '0;

  logic                 out_valid;
  logic [2:0]           out_status;
  logic [COMP_W-1:0]    out_pos_x, out_pos_y, out_pos_z;
  logic [COMP_W-1:0]    out_vel_x, out_vel_y, out_vel_z;
  logic [STAMP_W-1:0]   out_stamp;

  // shadow copy of the table
  logic [WGT_W-1:0]             smooth_weight = KEEP_WEIGHT_RST;
  int                           tgt_count = 0;
  logic [KEY_W-1:0]             tgt_key   [TABLE_ENTRIES];
  logic [2:0][COMP_W-1:0]       tgt_pos   [TABLE_ENTRIES];
  logic [2:0][COMP_W-1:0]       tgt_vel   [TABLE_ENTRIES];
  logic [STAMP_W-1:0]           tgt_stamp [TABLE_ENTRIES];

  track_report_t pending_reports[$];
  track_report_t want_rpt;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  tracked_target_smoothing_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_cmd.func),
    .in_target_id    (in_cmd.id),
    .in_pos_x        (in_cmd.pos[0]),
    .in_pos_y        (in_cmd.pos[1]),
    .in_pos_z        (in_cmd.pos[2]),
    .in_vel_x        (in_cmd.vel[0]),
    .in_vel_y        (in_cmd.vel[1]),
    .in_vel_z        (in_cmd.vel[2]),
    .in_stamp        (in_cmd.stamp),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_vel_x       (out_vel_x),
    .out_vel_y       (out_vel_y),
    .out_vel_z       (out_vel_z),
    .out_stamp       (out_stamp),
    .cfg_we          (cfg_we),
    .cfg_keep_weight (cfg_keep_weight)
  );

  function automatic int find_target(logic [KEY_W-1:0] id);
    for (int i = 0; i < tgt_count; i++) begin
      if (tgt_key[i] == id) return i;
    end
    return -1;
  endfunction

  // meas + floor(w * (old - meas) / 2^16), wrapped to 32 bits
  function automatic logic [COMP_W-1:0] smooth_comp(logic [COMP_W-1:0] old_v,
                                                    logic [COMP_W-1:0] meas);
    longint signed m, diff, prod, res;
    m    = longint'($signed(meas));
    diff = longint'($signed(old_v)) - m;
    prod = diff * $signed({48'd0, smooth_weight});
    res  = m + (prod >>> 16);
    return res[COMP_W-1:0];
  endfunction

  function automatic track_report_t apply_track_item(track_cmd_t c);
    track_report_t r;
    int slot;
    r = '0;
    slot = find_target(c.id);
    if (c.func == FUNC_READ) begin
      r.status = (slot >= 0) ? ST_FOUND : ST_NOT_FOUND;
    end else if (slot >= 0) begin
      for (int k = 0; k < 3; k++) begin
        tgt_pos[slot][k] = smooth_comp(tgt_pos[slot][k], c.pos[k]);
        tgt_vel[slot][k] = smooth_comp(tgt_vel[slot][k], c.vel[k]);
      end
      tgt_stamp[slot] = c.stamp;
      r.status = ST_UPDATED;
    end else if (tgt_count == TABLE_ENTRIES) begin
      r.status = ST_FULL;
    end else begin
      // entries are never freed, so the lowest free one is always the next
      slot = tgt_count;
      tgt_count++;
      tgt_key[slot]   = c.id;
      tgt_pos[slot]   = c.pos;
      tgt_vel[slot]   = c.vel;
      tgt_stamp[slot] = c.stamp;
      r.status = ST_CREATED;
    end
    if (slot >= 0) begin
      r.pos   = tgt_pos[slot];
      r.vel   = tgt_vel[slot];
      r.stamp = tgt_stamp[slot];
    end
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] rand_comp(logic [COMP_W-1:0] base);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return base + $urandom_range(0, 4095) - 2048;
    endcase
  endfunction

  function automatic track_cmd_t make_item(logic f, logic [KEY_W-1:0] id);
    track_cmd_t c;
    int slot;
    slot = find_target(id);
    c.func  = f;
    c.id    = id;
    c.stamp = {$urandom, $urandom};
    for (int k = 0; k < 3; k++) begin
      c.pos[k] = rand_comp((slot >= 0) ? tgt_pos[slot][k] : '0);
      c.vel[k] = rand_comp((slot >= 0) ? tgt_vel[slot][k] : '0);
    end
    return c;
  endfunction

  // measurement and stamp opposite to every stored bit of the entry
  function automatic track_cmd_t swing_item(logic [KEY_W-1:0] id);
    track_cmd_t c;
    int slot;
    slot = find_target(id);
    c.func  = FUNC_UPDATE;
    c.id    = id;
    c.pos   = ~tgt_pos[slot];
    c.vel   = ~tgt_vel[slot];
    c.stamp = ~tgt_stamp[slot];
    return c;
  endfunction

  task automatic send_item(track_cmd_t c);
    int gap;
    track_report_t rpt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
      @(negedge clk);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_cmd = c;
    start  = 1'b1;
    do @(posedge clk); while (busy);
    rpt = apply_track_item(c);
    pending_reports = {pending_reports, rpt};
  endtask

  task automatic drain_reports();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_weight(logic [WGT_W-1:0] w);
    drain_reports();
    cfg_we          = 1'b1;
    cfg_keep_weight = w;
    @(negedge clk);
    cfg_we = 1'b0;
    smooth_weight = w;
  endtask

  task automatic test_empty_reads();
    send_item(make_item(FUNC_READ, 16'h0000));
    send_item(make_item(FUNC_READ, 16'hFFFF));
  endtask

  task automatic test_create_extremes();
    track_cmd_t c;
    c.func  = FUNC_UPDATE;
    c.id    = 16'h0000;
    c.pos   = {32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    c.vel   = {32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
    c.stamp = '1;
    send_item(c);
    c.id    = 16'hFFFF;
    c.pos   = ~c.pos;
    c.vel   = ~c.vel;
    c.stamp = '0;
    send_item(c);
    send_item(make_item(FUNC_READ, 16'h0000));
    send_item(make_item(FUNC_READ, 16'hFFFF));
  endtask

  task automatic test_update_extremes();
    send_item(swing_item(16'h0000));
    send_item(swing_item(16'hFFFF));
    send_item(swing_item(16'h0000));
    send_item(make_item(FUNC_READ, 16'h0000));
  endtask

  task automatic test_weight_extremes();
    write_weight('0);
    send_item(make_item(FUNC_UPDATE, 16'hFFFF));
    write_weight('1);
    send_item(swing_item(16'h0000));
    send_item(swing_item(16'hFFFF));
    send_item(make_item(FUNC_READ, 16'h1234));
  endtask

  task automatic test_random_traffic(int n_items, logic [WGT_W-1:0] w);
    int sel;
    logic f;
    logic [KEY_W-1:0] id;
    write_weight(w);
    repeat (n_items) begin
      sel = $urandom_range(0, 99);
      id  = (tgt_count > 0) ? tgt_key[$urandom_range(0, tgt_count - 1)] : 16'(
            $urandom);
      f   = FUNC_UPDATE;
      if (tgt_count == 0 || sel < 12) begin
        id = 16'($urandom);
      end else if (sel < 62) begin
        f = FUNC_UPDATE;
      end else if (sel < 87) begin
        f = FUNC_READ;
      end else begin
        f  = FUNC_READ;
        id = 16'($urandom);
      end
      send_item(make_item(f, id));
    end
  endtask

  task automatic test_fill_to_full();
    logic [KEY_W-1:0] id;
    while (tgt_count < TABLE_ENTRIES) begin
      id = 16'($urandom);
      send_item(make_item(FUNC_UPDATE, id));
    end
    repeat (8) begin
      id = 16'($urandom);
      send_item(make_item(FUNC_UPDATE, id));
    end
  endtask

  task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d",
                 $time, out_status);
        err_cnt++;
      end else begin
        want_rpt = pending_reports.pop_front();
        cmp_field("status", 64'(want_rpt.status), 64'(out_status));
        cmp_field("pos_x", 64'(want_rpt.pos[0]), 64'(out_pos_x));
        cmp_field("pos_y", 64'(want_rpt.pos[1]), 64'(out_pos_y));
        cmp_field("pos_z", 64'(want_rpt.pos[2]), 64'(out_pos_z));
        cmp_field("vel_x", 64'(want_rpt.vel[0]), 64'(out_vel_x));
        cmp_field("vel_y", 64'(want_rpt.vel[1]), 64'(out_vel_y));
        cmp_field("vel_z", 64'(want_rpt.vel[2]), 64'(out_vel_z));
        cmp_field("stamp", want_rpt.stamp, out_stamp);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_empty_reads();
    test_create_extremes();
    test_update_extremes();
    test_weight_extremes();

    test_random_traffic(250, KEEP_WEIGHT_RST);
    test_random_traffic(250, 16'hFFFF);
    test_fill_to_full();
    test_random_traffic(250, 16'h0000);
    test_random_traffic(250, 16'h0001);
    test_random_traffic(250, 16'h8000);
    test_random_traffic(250, 16'($urandom));
    test_random_traffic(250, 16'($urandom));

    drain_reports();
    // quiet window: any late or extra strobe still gets caught
    repeat (TABLE_ENTRIES + 40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tts_pkg.sv
rtl/tts_dp.sv
rtl/tts_ctrl.sv
rtl/tracked_target_smoothing_table.sv
sim/tb_top.sv
